FILE: rtl/touch_zone_classifier_core_defines.svh
// Assertion macros shared by the touch zone classifier RTL.
`ifndef TOUCH_ZONE_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_ZONE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TZC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tzc_pkg.sv
package tzc_pkg;

  localparam logic [1:0] REG_WIDTH       = 2'd0;
  localparam logic [1:0] REG_HEIGHT      = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE    = 2'd2;
  localparam logic [1:0] REG_ORIENTATION = 2'd3;

  localparam logic [2:0] ORIENT_0 = 3'd0;
  localparam logic [2:0] ORIENT_1 = 3'd1;
  localparam logic [2:0] ORIENT_2 = 3'd2;
  localparam logic [2:0] ORIENT_3 = 3'd3;

  localparam logic [3:0] ZONE_NONE   = 4'd0;
  localparam logic [3:0] ZONE_CENTRE = 4'd5;
  localparam logic [3:0] ZONE_LONG   = 4'd10;

  localparam logic [31:0] LONG_PRESS_MS = 32'd1500;

  // Resistive panels span 200..3800; the span of 3600 is divided out by
  // multiplying with ceil(2^34 / 3600), exact for products below 2^22.
  localparam logic [11:0] RES_IN_LOW  = 12'd200;
  localparam logic [22:0] RES_RECIP   = 23'd4772186;
  localparam int          RES_SHIFT   = 34;

  // Division by three of values below 2048: multiply by 683, shift by 11.
  localparam logic [10:0] THIRD_RECIP = 11'd683;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [9:0]  width;
    logic [9:0]  height;
    logic [15:0] debounce;
    logic [2:0]  orientation;
  } cfg_t;

  typedef struct packed {
    logic        touched;
    logic [3:0]  zone;
    logic [31:0] time_ms;
  } zone_item_t;

endpackage

FILE: rtl/tzc_if.sv
interface tzc_in_if;
  logic        valid;
  logic        ready;
  logic        touched;
  logic [11:0] raw_x;
  logic [11:0] raw_y;
  logic [31:0] time_ms;

  modport source(output valid, output touched, output raw_x, output raw_y,
                 output time_ms, input ready);
  modport sink(input valid, input touched, input raw_x, input raw_y,
               input time_ms, output ready);
endinterface

interface tzc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] zone;

  modport source(output valid, output zone, input ready);
  modport sink(input valid, input zone, output ready);
endinterface

FILE: rtl/tzc_front.sv
`include "touch_zone_classifier_core_defines.svh"

module tzc_front import tzc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  tzc_in_if.sink      samples,
  input  logic        q_full,
  output logic        push,
  output zone_item_t  push_item
);

  logic advance;

  logic [9:0] wl;
  logic [9:0] hl;

  // Stage 1: raw sample and scale products.
  logic        v1;
  logic        touched1;
  logic [11:0] rx1;
  logic [11:0] ry1;
  logic [31:0] time1;
  logic        cap1;
  logic        portrait1;
  logic [21:0] prod_x1;
  logic [21:0] prod_y1;

  // Stage 2: scaled resistive coordinates.
  logic        v2;
  logic        touched2;
  logic [11:0] rx2;
  logic [11:0] ry2;
  logic [31:0] time2;
  logic        cap2;
  logic        portrait2;
  logic [9:0]  lx2;
  logic [9:0]  ly2;

  // Stage 3: rotated and clamped point.
  logic        v3;
  logic        touched3;
  logic [31:0] time3;
  logic signed [10:0] x3;
  logic signed [10:0] y3;

  logic [11:0] dx;
  logic [11:0] dy;
  logic        cap_in;
  logic        portrait_in;
  logic [44:0] qx_full;
  logic [44:0] qy_full;
  logic [10:0] qx;
  logic [10:0] qy;

  logic signed [12:0] rxs;
  logic signed [12:0] rys;
  logic signed [12:0] lxs;
  logic signed [12:0] lys;
  logic signed [12:0] wls;
  logic signed [12:0] hls;
  logic signed [12:0] ws;
  logic signed [12:0] hs;
  logic signed [12:0] xr;
  logic signed [12:0] yr;
  logic signed [12:0] xa;
  logic signed [12:0] ya;
  logic signed [12:0] xc;
  logic signed [12:0] yc;

  logic [11:0] h3x;
  logic [9:0]  h_q1;
  logic [9:0]  h_q3;
  logic [19:0] w_mul1;
  logic [20:0] w_mul2;
  logic [9:0]  w_t1;
  logic [9:0]  w_t2;
  logic [1:0]  row;
  logic [1:0]  col;

  assign wl = (cfg.width > cfg.height) ? cfg.width : cfg.height;
  assign hl = (cfg.width < cfg.height) ? cfg.width : cfg.height;

  assign advance       = !v3 || !q_full;
  assign samples.ready = advance;
  assign push          = v3 && !q_full;

  assign dx = (samples.raw_x > RES_IN_LOW) ? samples.raw_x - RES_IN_LOW : 12'd0;
  assign dy = (samples.raw_y > RES_IN_LOW) ? samples.raw_y - RES_IN_LOW : 12'd0;
  assign cap_in = (samples.raw_x <= {1'b0, cfg.width, 1'b0}) &&
                  (samples.raw_y <= {1'b0, cfg.height, 1'b0});
  assign portrait_in = (samples.raw_x <= {2'b0, hl}) && (samples.raw_y <= {2'b0, wl});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= samples.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      touched1  <= samples.touched;
      rx1       <= samples.raw_x;
      ry1       <= samples.raw_y;
      time1     <= samples.time_ms;
      cap1      <= cap_in;
      portrait1 <= portrait_in;
      prod_x1   <= {10'b0, dx} * {12'b0, wl};
      prod_y1   <= {10'b0, dy} * {12'b0, hl};
    end
  end

  assign qx_full = {23'b0, prod_x1} * {22'b0, RES_RECIP};
  assign qy_full = {23'b0, prod_y1} * {22'b0, RES_RECIP};
  assign qx = qx_full[RES_SHIFT+10:RES_SHIFT];
  assign qy = qy_full[RES_SHIFT+10:RES_SHIFT];

  always_ff @(posedge clk) begin
    if (advance) begin
      touched2  <= touched1;
      rx2       <= rx1;
      ry2       <= ry1;
      time2     <= time1;
      cap2      <= cap1;
      portrait2 <= portrait1;
      lx2       <= (qx > {1'b0, wl}) ? wl : qx[9:0];
      ly2       <= (qy > {1'b0, hl}) ? hl : qy[9:0];
    end
  end

  assign rxs = $signed({1'b0, rx2});
  assign rys = $signed({1'b0, ry2});
  assign lxs = $signed({3'b0, lx2});
  assign lys = $signed({3'b0, ly2});
  assign wls = $signed({3'b0, wl});
  assign hls = $signed({3'b0, hl});
  assign ws  = $signed({3'b0, cfg.width});
  assign hs  = $signed({3'b0, cfg.height});

  always_comb begin
    xr = lxs;
    yr = lys;
    if (cap2 && portrait2) begin
      unique case (cfg.orientation)
        ORIENT_0: begin xr = rxs;       yr = rys;       end
        ORIENT_1: begin xr = rys;       yr = hls - rxs; end
        ORIENT_2: begin xr = hls - rxs; yr = wls - rys; end
        ORIENT_3: begin xr = wls - rys; yr = rxs;       end
        default:  begin xr = rys;       yr = rxs;       end
      endcase
    end else if (cap2) begin
      unique case (cfg.orientation)
        ORIENT_0: begin xr = hls - rys; yr = wls - rxs; end
        ORIENT_1: begin xr = rxs;       yr = rys;       end
        ORIENT_2: begin xr = rys;       yr = rxs;       end
        ORIENT_3: begin xr = wls - rxs; yr = hls - rys; end
        default:  begin xr = rxs;       yr = rys;       end
      endcase
    end else begin
      unique case (cfg.orientation)
        ORIENT_0: begin xr = hls - lys; yr = lxs;       end
        ORIENT_1: begin xr = lxs;       yr = lys;       end
        ORIENT_2: begin xr = lys;       yr = wls - lxs; end
        ORIENT_3: begin xr = wls - lxs; yr = hls - lys; end
        default:  begin xr = lxs;       yr = lys;       end
      endcase
    end
  end

  // A zero display size clamps to minus one, classified as the first row or column.
  assign xa = (xr < 13'sd0) ? 13'sd0 : xr;
  assign ya = (yr < 13'sd0) ? 13'sd0 : yr;
  assign xc = (xa >= ws) ? ws - 13'sd1 : xa;
  assign yc = (ya >= hs) ? hs - 13'sd1 : ya;

  always_ff @(posedge clk) begin
    if (advance) begin
      touched3 <= touched2;
      time3    <= time2;
      x3       <= xc[10:0];
      y3       <= yc[10:0];
    end
  end

  assign h3x    = {2'b0, cfg.height} + {1'b0, cfg.height, 1'b0};
  assign h_q1   = {2'b0, cfg.height[9:2]};
  assign h_q3   = h3x[11:2];
  assign w_mul1 = {10'b0, cfg.width} * {9'b0, THIRD_RECIP};
  assign w_mul2 = {10'b0, cfg.width, 1'b0} * {10'b0, THIRD_RECIP};
  assign w_t1   = {1'b0, w_mul1[19:11]};
  assign w_t2   = w_mul2[20:11];

  always_comb begin
    if (y3 < $signed({1'b0, h_q1})) begin
      row = 2'd0;
    end else if (y3 >= $signed({1'b0, h_q3})) begin
      row = 2'd2;
    end else begin
      row = 2'd1;
    end
    if (x3 < $signed({1'b0, w_t1})) begin
      col = 2'd0;
    end else if (x3 >= $signed({1'b0, w_t2})) begin
      col = 2'd2;
    end else begin
      col = 2'd1;
    end
  end

  assign push_item.touched = touched3;
  assign push_item.time_ms = time3;
  assign push_item.zone    = {1'b0, row, 1'b0} + {2'b0, row} + {2'b0, col} + 4'd1;

  `TZC_ASSERT_NOW(a_zone_in_grid, clk, rst, push, (push_item.zone != ZONE_NONE) && (push_item.zone <= 4'd9), "front produced a zone outside the grid")

endmodule

FILE: rtl/tzc_fifo.sv
`include "touch_zone_classifier_core_defines.svh"

module tzc_fifo import tzc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  zone_item_t  push_item,
  input  logic        pop,
  output zone_item_t  pop_item,
  output logic        full,
  output logic        empty
);

  zone_item_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr;
  logic [FIFO_AW-1:0]     rd_ptr;
  logic [FIFO_CW-1:0]     count;

  assign full     = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `TZC_ASSERT_NOW(a_no_overflow, clk, rst, 1'b1, !(push && full) && !(pop && empty), "queue written while full or read while empty")
  `TZC_ASSERT_NEXT(a_count_track, clk, rst, 1'b1, count == $past(count) + FIFO_CW'($past(push)) - FIFO_CW'($past(pop)), "queue fill count out of step")

endmodule

FILE: rtl/tzc_back.sv
`include "touch_zone_classifier_core_defines.svh"

module tzc_back import tzc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] debounce,
  input  zone_item_t  item,
  input  logic        empty,
  output logic        pop,
  tzc_out_if.source   zones
);

  logic        press_active;
  logic [3:0]  start_zone;
  logic        long_press_done;
  logic [31:0] press_start_time;
  logic [31:0] last_tap_time;
  logic        out_valid;
  logic [3:0]  out_zone;

  logic        press_active_next;
  logic [3:0]  start_zone_next;
  logic        long_press_done_next;
  logic [31:0] press_start_time_next;
  logic [31:0] last_tap_time_next;
  logic [3:0]  result;
  logic [31:0] since_tap;
  logic [31:0] since_press;

  assign pop         = !empty && (!out_valid || zones.ready);
  assign zones.valid = out_valid;
  assign zones.zone  = out_zone;

  assign since_tap   = item.time_ms - last_tap_time;
  assign since_press = item.time_ms - press_start_time;

  always_comb begin
    press_active_next     = press_active;
    start_zone_next       = start_zone;
    long_press_done_next  = long_press_done;
    press_start_time_next = press_start_time;
    last_tap_time_next    = last_tap_time;
    result                = ZONE_NONE;
    if (!item.touched) begin
      press_active_next    = 1'b0;
      start_zone_next      = ZONE_NONE;
      long_press_done_next = 1'b0;
    end else if (!press_active || item.zone != start_zone) begin
      if (since_tap >= {16'b0, debounce}) begin
        press_active_next     = 1'b1;
        press_start_time_next = item.time_ms;
        start_zone_next       = item.zone;
        long_press_done_next  = 1'b0;
        last_tap_time_next    = item.time_ms;
        result                = item.zone;
      end
    end else if (item.zone == ZONE_CENTRE && !long_press_done &&
                 since_press >= LONG_PRESS_MS) begin
      long_press_done_next = 1'b1;
      result               = ZONE_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_active     <= 1'b0;
      start_zone       <= ZONE_NONE;
      long_press_done  <= 1'b0;
      press_start_time <= '0;
      last_tap_time    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        press_active     <= press_active_next;
        start_zone       <= start_zone_next;
        long_press_done  <= long_press_done_next;
        press_start_time <= press_start_time_next;
        last_tap_time    <= last_tap_time_next;
        out_valid        <= 1'b1;
      end else if (zones.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_zone <= result;
    end
  end

  `TZC_ASSERT_NOW(a_long_needs_centre, clk, rst, pop && (result == ZONE_LONG), press_active && (start_zone == ZONE_CENTRE) && !long_press_done, "long press reported without a centre hold")
  `TZC_ASSERT_NOW(a_zone_range, clk, rst, out_valid, out_zone <= ZONE_LONG, "reported zone out of range")

endmodule

FILE: rtl/touch_zone_classifier_core.sv
// A result beat passes the three classifier stages, the four-entry queue and the
// press tracker's output register. Throughput: one sample per cycle while the
// queue is not full; the queue lets classifier and tracker each stall on its own.
// Reset (synchronous, active high) clears press and tap state and loads width 320,
// height 240, debounce 300 ms and orientation 1.
`include "touch_zone_classifier_core_defines.svh"

module touch_zone_classifier_core import tzc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  tzc_in_if.sink      samples,
  tzc_out_if.source   zones
);

  cfg_t       cfg;
  logic       push;
  zone_item_t push_item;
  logic       pop;
  zone_item_t pop_item;
  logic       q_full;
  logic       q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width       <= 10'd320;
      cfg.height      <= 10'd240;
      cfg.debounce    <= 16'd300;
      cfg.orientation <= ORIENT_1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:       cfg.width       <= cfg_data[9:0];
        REG_HEIGHT:      cfg.height      <= cfg_data[9:0];
        REG_DEBOUNCE:    cfg.debounce    <= cfg_data;
        REG_ORIENTATION: cfg.orientation <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  tzc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tzc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  tzc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .debounce (cfg.debounce),
    .item     (pop_item),
    .empty    (q_empty),
    .pop      (pop),
    .zones    (zones)
  );

  `TZC_ASSERT_NOW(a_release_clears, clk, rst, zones.valid && !$past(q_empty) && $past(pop) && !$past(pop_item.touched), zones.zone == ZONE_NONE, "release sample reported a zone")

endmodule
